// ----- hw/rtl/rcpd_pkg.sv -----
`default_nettype none

package rcpd_pkg;

    localparam int NUM_CHANNELS = 7;
    localparam int TIME_BITS    = 16;
    localparam int VALUE_BITS   = 10;
    // stored value keeps one bit of headroom over the delivered value
    localparam int STORE_BITS   = 11;

    localparam int IN_BITS      = NUM_CHANNELS + TIME_BITS;
    localparam int IN_BYTES     = (IN_BITS + 7) / 8;
    localparam int OUT_BITS     = NUM_CHANNELS * VALUE_BITS + NUM_CHANNELS;
    localparam int OUT_BYTES    = (OUT_BITS + 7) / 8;

    localparam logic [TIME_BITS-1:0]         WIDTH_MIN = TIME_BITS'(1000);
    localparam logic [TIME_BITS-1:0]         WIDTH_MAX = TIME_BITS'(2000);
    localparam logic [STORE_BITS-1:0]        WIDTH_MID = STORE_BITS'(1500);
    localparam logic signed [STORE_BITS-1:0] VALUE_LOW  = -STORE_BITS'(500);
    localparam logic signed [STORE_BITS-1:0] VALUE_HIGH = STORE_BITS'(500);

    localparam logic [NUM_CHANNELS-1:0] INVERT_RESET = NUM_CHANNELS'(8'h0a);

    typedef struct packed {
        logic [NUM_CHANNELS-1:0] levels;
        logic [TIME_BITS-1:0]    now;
    } t_sample;

endpackage

`default_nettype wire

// ----- hw/rtl/rc_pwm_pulse_decoder_unit.sv -----
`default_nettype none

// channel   dir  tdata fields (lsb up)                         handshake
// s         in   pin_levels[6:0], timestamp_us[22:7], pad     i_s_tvalid / o_s_tready
// m         out  chan0..chan6_value 10b each, updated_mask     o_m_tvalid / i_m_tready
// cfg       in   invert_mask[6:0]                              i_cfg_wr_en, no wait
//
// accepted words go via the input register and decode stage into the output register
// one word per cycle unless the master stalls; channel state updates in the decode stage
// synchronous active-low reset clears the stage valids, edge history, rise times and
// channel values (channel 0 to -500); it sets the invert mask to channels 1 and 3
// a stall on the master side holds the output word and backs up through the input stage

module rc_pwm_pulse_decoder_unit (
    input  wire                                    i_clk,
    input  wire                                    i_rst_n,
    // slave side: pin_levels, timestamp_us, zero pad
    input  wire                                    i_s_tvalid,
    output logic                                   o_s_tready,
    input  wire [rcpd_pkg::IN_BYTES*8-1:0]         i_s_tdata,
    // master side: chan0_value .. chan6_value, updated_mask, zero pad
    output logic                                   o_m_tvalid,
    input  wire                                    i_m_tready,
    output logic [rcpd_pkg::OUT_BYTES*8-1:0]       o_m_tdata,
    // invert mask register
    input  wire                                    i_cfg_wr_en,
    input  wire [rcpd_pkg::NUM_CHANNELS-1:0]       i_cfg_wr_data
);
    import rcpd_pkg::*;

    t_sample in_sample;
    t_sample stage_sample;
    logic    stage_valid;
    logic    advance;

    // configuration
    logic [NUM_CHANNELS-1:0] r_invert;

    // channel state
    logic [NUM_CHANNELS-1:0]         r_prev;
    logic [TIME_BITS-1:0]            r_rise  [NUM_CHANNELS];
    logic signed [STORE_BITS-1:0]    r_value [NUM_CHANNELS];
    logic [TIME_BITS-1:0]            n_rise  [NUM_CHANNELS];
    logic signed [STORE_BITS-1:0]    n_value [NUM_CHANNELS];
    logic [NUM_CHANNELS-1:0]         n_updated;

    // output register
    logic                    r_out_valid;
    logic [OUT_BYTES*8-1:0]  r_out_data;
    logic [OUT_BYTES*8-1:0]  n_out_data;

    assign in_sample.levels = i_s_tdata[NUM_CHANNELS-1:0];
    assign in_sample.now    = i_s_tdata[IN_BITS-1:NUM_CHANNELS];

    // decode stage moves when the output register is empty or being drained
    assign advance = stage_valid && (!r_out_valid || i_m_tready);

    rcpd_in_reg u_in_reg (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_s_tvalid),
        .o_ready   (o_s_tready),
        .i_sample  (in_sample),
        .i_advance (advance),
        .o_valid   (stage_valid),
        .o_sample  (stage_sample)
    );

    // one decode lane per channel, all in parallel
    for (genvar n = 0; n < NUM_CHANNELS; n++) begin : g_lane
        rcpd_chan_lane u_lane (
            .i_level   (stage_sample.levels[n]),
            .i_prev    (r_prev[n]),
            .i_invert  (r_invert[n]),
            .i_now     (stage_sample.now),
            .i_rise    (r_rise[n]),
            .i_value   (r_value[n]),
            .o_rise    (n_rise[n]),
            .o_value   (n_value[n]),
            .o_updated (n_updated[n])
        );
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_invert <= INVERT_RESET;
        end else if (i_cfg_wr_en) begin
            r_invert <= i_cfg_wr_data;
        end
    end

    // state commits when the decode stage hands its word to the output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev <= '0;
            for (int n = 0; n < NUM_CHANNELS; n++) begin
                r_rise[n]  <= '0;
                r_value[n] <= (n == 0) ? VALUE_LOW : '0;
            end
        end else if (advance) begin
            r_prev <= stage_sample.levels;
            for (int n = 0; n < NUM_CHANNELS; n++) begin
                r_rise[n]  <= n_rise[n];
                r_value[n] <= n_value[n];
            end
        end
    end

    // pack values low first, then the updated mask, zero pad on top
    always_comb begin
        n_out_data = '0;
        for (int n = 0; n < NUM_CHANNELS; n++) begin
            n_out_data[n*VALUE_BITS +: VALUE_BITS] = n_value[n][VALUE_BITS-1:0];
        end
        n_out_data[NUM_CHANNELS*VALUE_BITS +: NUM_CHANNELS] = n_updated;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out_data <= n_out_data;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_out_data;

endmodule

`default_nettype wire

// ----- hw/rtl/rcpd_in_reg.sv -----
`default_nettype none

module rcpd_in_reg (
    input  wire                    i_clk,
    input  wire                    i_rst_n,
    input  wire                    i_valid,
    output logic                   o_ready,
    input  rcpd_pkg::t_sample      i_sample,
    input  wire                    i_advance,
    output logic                   o_valid,
    output rcpd_pkg::t_sample      o_sample
);
    import rcpd_pkg::*;

    logic    r_valid;
    t_sample r_sample;

    // slot frees when empty or when its word moves on this cycle
    assign o_ready  = !r_valid || i_advance;
    assign o_valid  = r_valid;
    assign o_sample = r_sample;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_sample <= i_sample;
        end
    end

endmodule

`default_nettype wire

// ----- hw/rtl/rcpd_chan_lane.sv -----
`default_nettype none

module rcpd_chan_lane (
    input  wire                                        i_level,
    input  wire                                        i_prev,
    input  wire                                        i_invert,
    input  wire [rcpd_pkg::TIME_BITS-1:0]              i_now,
    input  wire [rcpd_pkg::TIME_BITS-1:0]              i_rise,
    input  wire signed [rcpd_pkg::STORE_BITS-1:0]      i_value,
    output logic [rcpd_pkg::TIME_BITS-1:0]             o_rise,
    output logic signed [rcpd_pkg::STORE_BITS-1:0]     o_value,
    output logic                                       o_updated
);
    import rcpd_pkg::*;

    logic [TIME_BITS-1:0]         width;
    logic signed [STORE_BITS-1:0] base;
    logic signed [STORE_BITS-1:0] decoded;

    // pulse width wraps with the timestamp
    assign width = i_now - i_rise;

    always_comb begin
        if (width < WIDTH_MIN) begin
            base = VALUE_LOW;
        end else if (width > WIDTH_MAX) begin
            base = VALUE_HIGH;
        end else begin
            // in range the width fits the stored width, offset modulo 2^STORE_BITS
            base = signed'(width[STORE_BITS-1:0] - WIDTH_MID);
        end
        decoded = i_invert ? -base : base;
    end

    always_comb begin
        o_rise    = i_rise;
        o_value   = i_value;
        o_updated = 1'b0;
        if (i_level && !i_prev) begin
            o_rise = i_now;
        end else if (!i_level && i_prev) begin
            o_value   = decoded;
            o_updated = 1'b1;
        end
    end

endmodule

`default_nettype wire

// ----- test/rc_pwm_pulse_decoder_unit_test.sv -----
`default_nettype none

// bench for the rc pulse-width decoder
// drives pin/timestamp samples on the slave stream, tracks rise times and
// channel values in a class of its own, and checks every decoded word on the
// master stream field by field in order of acceptance

module rc_pwm_pulse_decoder_unit_test;

    import rcpd_pkg::*;

    localparam int OUT_PAD = OUT_BYTES * 8 - OUT_BITS;

    // one decoded word as it sits on o_m_tdata, chan0 in the lowest bits
    typedef struct packed {
        logic [OUT_PAD-1:0]                       pad;
        logic [NUM_CHANNELS-1:0]                  updated;
        logic [NUM_CHANNELS-1:0][VALUE_BITS-1:0] value;
    } t_decoded_word;

    // receiver stall patterns, one picked at random whenever ready_phase wraps
    typedef enum int {
        READY_ALWAYS,
        READY_RANDOM,
        READY_PERIODIC,
        READY_LONG_STALL
    } t_ready_mode;

    // keeps its own copy of edge history, rise times and channel values
    class channel_value_tracker;
        logic [NUM_CHANNELS-1:0]      invert_bits;
        logic [NUM_CHANNELS-1:0]      last_levels;
        logic [TIME_BITS-1:0]         rise_stamp [NUM_CHANNELS];
        logic signed [STORE_BITS-1:0] chan_val [NUM_CHANNELS];
        t_decoded_word                expected_words [$];
        int                           mismatch_count;

        function new();
            invert_bits = INVERT_RESET;
            last_levels = '0;
            for (int n = 0; n < NUM_CHANNELS; n++) begin
                rise_stamp[n] = '0;
                chan_val[n]   = '0;
            end
            chan_val[0]    = VALUE_LOW;
            mismatch_count = 0;
        endfunction

        function void set_invert(logic [NUM_CHANNELS-1:0] bits);
            invert_bits = bits;
        endfunction

        function int pending();
            return expected_words.size();
        endfunction

        // one accepted sample: update the channel state, queue the decoded word
        function void note_sample(logic [NUM_CHANNELS-1:0] levels, logic [TIME_BITS-1:0] now);
            logic [NUM_CHANNELS-1:0] changed;
            logic [TIME_BITS-1:0]    width;
            int                      v;
            t_decoded_word           w;
            changed = levels ^ last_levels;
            w = '0;
            for (int n = 0; n < NUM_CHANNELS; n++) begin
                if (changed[n]) begin
                    if (levels[n]) begin
                        rise_stamp[n] = now;
                    end else begin
                        // width wraps with the timestamp
                        width = now - rise_stamp[n];
                        if (width < WIDTH_MIN) width = WIDTH_MIN;
                        if (width > WIDTH_MAX) width = WIDTH_MAX;
                        v = int'(width) - 1500;
                        if (invert_bits[n]) v = -v;
                        chan_val[n] = STORE_BITS'(v);
                        w.updated[n] = 1'b1;
                    end
                end
            end
            last_levels = levels;
            for (int n = 0; n < NUM_CHANNELS; n++) begin
                w.value[n] = chan_val[n][VALUE_BITS-1:0];
            end
            expected_words.push_back(w);
        endfunction

        task report_mismatch(string what, int got, int want);
            mismatch_count++;
            $display("mismatch %s: got %0d, expected %0d", what, got, want);
        endtask

        task check_word(t_decoded_word got);
            t_decoded_word want;
            if (expected_words.size() == 0) begin
                report_mismatch("word with nothing pending, updated_mask", got.updated, 0);
            end else begin
                want = expected_words.pop_front();
                for (int n = 0; n < NUM_CHANNELS; n++) begin
                    if (got.value[n] !== want.value[n]) begin
                        report_mismatch($sformatf("chan%0d_value", n),
                                        int'($signed(got.value[n])),
                                        int'($signed(want.value[n])));
                    end
                end
                if (got.updated !== want.updated) begin
                    report_mismatch("updated_mask", got.updated, want.updated);
                end
            end
        endtask
    endclass

    logic                      i_clk;
    logic                      i_rst_n;
    logic                      i_s_tvalid;
    logic                      o_s_tready;
    // pin_levels[6:0], timestamp_us[22:7], zero pad
    logic [IN_BYTES*8-1:0]     i_s_tdata;
    logic                      o_m_tvalid;
    logic                      i_m_tready = 1'b0;
    // chan0_value[9:0] .. chan6_value[69:60], updated_mask[76:70], zero pad
    logic [OUT_BYTES*8-1:0]    o_m_tdata;
    logic                      i_cfg_wr_en;
    logic [NUM_CHANNELS-1:0]   i_cfg_wr_data;

    channel_value_tracker sb = new();

    // pulse generator state for the well-formed part of the stimulus
    logic [TIME_BITS-1:0]    gen_now;
    logic [NUM_CHANNELS-1:0] gen_levels;
    logic [TIME_BITS-1:0]    gen_mark [NUM_CHANNELS];
    logic [TIME_BITS-1:0]    gen_len [NUM_CHANNELS];

    // receiver stall pattern state
    t_ready_mode ready_mode  = READY_ALWAYS;
    logic [6:0]  ready_phase = '0;

    rc_pwm_pulse_decoder_unit dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_s_tvalid    (i_s_tvalid),
        .o_s_tready    (o_s_tready),
        .i_s_tdata     (i_s_tdata),
        .o_m_tvalid    (o_m_tvalid),
        .i_m_tready    (i_m_tready),
        .o_m_tdata     (o_m_tdata),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data)
    );

    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    // receiver side: ready moves on the falling edge, pattern picked anew when ready_phase wraps
    always @(negedge i_clk) begin
        ready_phase = ready_phase + 1'b1;
        if (ready_phase == '0) begin
            ready_mode = t_ready_mode'($urandom_range(0, 3));
        end
        case (ready_mode)
            READY_ALWAYS: begin
                i_m_tready = 1'b1;
            end
            READY_RANDOM: begin
                i_m_tready = ($urandom_range(0, 3) != 0);
            end
            READY_PERIODIC: begin
                i_m_tready = (ready_phase[2:0] < 3'd5);
            end
            default: begin
                // long stall, ready held low until ready_phase[4:0] reaches 20
                i_m_tready = (ready_phase[4:0] >= 5'd20);
            end
        endcase
    end

    // output monitor, sampled at the rising edge
    always @(posedge i_clk) begin
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            sb.check_word(t_decoded_word'(o_m_tdata));
        end
    end

    // one sample word, held until accepted
    task send_sample(logic [NUM_CHANNELS-1:0] levels, logic [TIME_BITS-1:0] now);
        @(negedge i_clk);
        i_s_tvalid = 1'b1;
        i_s_tdata  = '0;
        i_s_tdata[NUM_CHANNELS-1:0]                      = levels;
        i_s_tdata[NUM_CHANNELS+TIME_BITS-1:NUM_CHANNELS] = now;
        do @(posedge i_clk); while (!o_s_tready);
        sb.note_sample(levels, now);
    endtask

    task sender_idle(int cycles);
        repeat (cycles) begin
            @(negedge i_clk);
            i_s_tvalid = 1'b0;
        end
    endtask

    // stop sending and wait for every pending word to come out
    task wait_drained();
        int guard;
        guard = 0;
        @(negedge i_clk);
        i_s_tvalid = 1'b0;
        while (sb.pending() != 0 && guard < 50000) begin
            @(posedge i_clk);
            guard++;
        end
    endtask

    // register write only with the pipeline empty and idle
    task write_invert(logic [NUM_CHANNELS-1:0] bits);
        wait_drained();
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_cfg_wr_en   = 1'b1;
        i_cfg_wr_data = bits;
        sb.set_invert(bits);
        @(negedge i_clk);
        i_cfg_wr_en   = 1'b0;
    endtask

    // next high time (pulse width) or low time for the generator
    function logic [TIME_BITS-1:0] pick_len(logic level);
        int sel;
        sel = $urandom_range(0, 19);
        if (!level) begin
            return TIME_BITS'($urandom_range(0, 3000));
        end
        case (sel)
            0: return TIME_BITS'($urandom_range(0, 999));
            1: return TIME_BITS'($urandom_range(2001, 65535));
            2: begin
                // right at the clamp boundaries
                case ($urandom_range(0, 3))
                    0: return TIME_BITS'(999);
                    1: return TIME_BITS'(1000);
                    2: return TIME_BITS'(2000);
                    default: return TIME_BITS'(2001);
                endcase
            end
            default: return TIME_BITS'($urandom_range(950, 2050));
        endcase
    endfunction

    // mostly well-formed pulse trains, some noise and broken edges
    task run_phase(int count, bit gappy);
        int                      burst_left;
        int                      sel;
        logic [NUM_CHANNELS-1:0] lv;
        logic [TIME_BITS-1:0]    ts;
        burst_left = $urandom_range(1, 30);
        repeat (count) begin
            sel = $urandom_range(0, 99);
            if (sel < 4) begin
                // noise sample
                lv = NUM_CHANNELS'($urandom);
                ts = TIME_BITS'($urandom);
            end else begin
                if (sel < 6) gen_now = gen_now + TIME_BITS'($urandom_range(0, 65535));
                else         gen_now = gen_now + TIME_BITS'($urandom_range(1, 150));
                for (int n = 0; n < NUM_CHANNELS; n++) begin
                    if (TIME_BITS'(gen_now - gen_mark[n]) >= gen_len[n]) begin
                        gen_levels[n] = ~gen_levels[n];
                        gen_mark[n]   = gen_now;
                        gen_len[n]    = pick_len(gen_levels[n]);
                    end
                end
                lv = gen_levels;
                ts = gen_now;
                // broken pulse: a stray edge on one pin
                if (sel >= 97) lv[$urandom_range(0, NUM_CHANNELS-1)] ^= 1'b1;
            end
            send_sample(lv, ts);
            burst_left--;
            if (burst_left == 0) begin
                burst_left = $urandom_range(1, 30);
                if (gappy) sender_idle($urandom_range(1, 8));
                if ($urandom_range(0, 49) == 0) wait_drained();
            end
        end
    endtask

    initial begin
        i_rst_n       = 1'b0;
        i_s_tvalid    = 1'b0;
        i_s_tdata     = '0;
        i_cfg_wr_en   = 1'b0;
        i_cfg_wr_data = '0;
        gen_now       = '0;
        gen_levels    = '0;
        for (int n = 0; n < NUM_CHANNELS; n++) begin
            gen_mark[n] = '0;
            gen_len[n]  = pick_len(1'b0);
        end
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // directed part, reset invert mask (channels 1 and 3)
        send_sample(7'h7f, 16'd100);    // first sample all high: every pin rises
        send_sample(7'h7e, 16'd1099);   // ch0 width 999, clamps low
        send_sample(7'h7c, 16'd1100);   // ch1 width 1000, inverted
        send_sample(7'h78, 16'd1600);   // ch2 mid width
        send_sample(7'h70, 16'd2100);   // ch3 width 2000, inverted
        send_sample(7'h60, 16'd2101);   // ch4 width 2001, clamps high
        send_sample(7'h40, 16'd2200);   // ch5 over range
        send_sample(7'h00, 16'd100);    // ch6 width zero
        send_sample(7'h01, 16'd65000);  // ch0 rises near the wrap
        send_sample(7'h00, 16'd964);    // width across the wrap, 1500
        send_sample(7'h7f, 16'd65535);  // top timestamp
        send_sample(7'h7f, 16'd0);      // no change
        send_sample(7'h00, 16'd65534);  // width 65535, clamps high
        send_sample(7'h55, 16'd0);
        send_sample(7'h2a, 16'd1234);   // evens fall, odds rise together
        send_sample(7'h00, 16'd3000);
        send_sample(7'h00, 16'd3001);   // idle sample, nothing updated

        // random part under several invert settings, extremes among them
        write_invert(7'h7f);
        run_phase(245, 1'b1);
        write_invert(NUM_CHANNELS'($urandom));
        run_phase(245, 1'b0);
        write_invert(7'h00);
        run_phase(245, 1'b1);
        write_invert(NUM_CHANNELS'($urandom));
        run_phase(245, 1'b0);
        write_invert(7'h55);
        run_phase(245, 1'b1);

        wait_drained();
        repeat (8) @(posedge i_clk);
        if (sb.pending() != 0) begin
            sb.report_mismatch("words never delivered", 0, sb.pending());
        end
        if (sb.mismatch_count == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

    // hard limit on the run
    initial begin
        #4000000;
        $display("TB_ERROR");
        $finish;
    end

endmodule

`default_nettype wire

// ----- files.f -----
hw/rtl/rcpd_pkg.sv
hw/rtl/rcpd_in_reg.sv
hw/rtl/rcpd_chan_lane.sv
hw/rtl/rc_pwm_pulse_decoder_unit.sv
test/rc_pwm_pulse_decoder_unit_test.sv
